>>> hdl/sms_pkg.sv
`default_nettype none
package sms_pkg;

	// Field widths
	localparam int STEP_BITS = 17;
	localparam int POSITION_BITS = 31;
	localparam int PERIOD_BITS = 26;
	localparam int SPR_BITS = 16;
	localparam int RPM_BITS = 8;
	localparam int CFG_DATA_BITS = 16;
	localparam int CFG_INDEX_BITS = 1;

	// Stream payload widths, padded to whole bytes
	localparam int IN_DATA_BITS = ((STEP_BITS + 7) / 8) * 8;
	localparam int OUT_FIELD_BITS = 4 + 1 + 1 + 1 + 2 * POSITION_BITS;
	localparam int OUT_DATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

	// Period divider sizing: steps_per_rev * rpm product and the dividend
	localparam int PROD_BITS = SPR_BITS + RPM_BITS;
	localparam int DVD_BITS = 26;
	localparam int CNT_BITS = 5;
	// ceil(a / b) = floor((a - 1) / b) + 1, so divide one less than 60e6
	localparam logic [DVD_BITS-1:0] DIVIDEND = DVD_BITS'(60_000_000 - 1);
	localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = '1;
	localparam logic [DVD_BITS:0] PERIOD_CAP = (DVD_BITS + 1)'((64'd1 << PERIOD_BITS) - 64'd1);

	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

	// Configuration register indexes
	localparam logic [CFG_INDEX_BITS-1:0] CFG_STEPS_PER_REV = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SPEED_RPM = 1'b1;
	localparam logic [SPR_BITS-1:0] SPR_RESET = 16'd2048;
	localparam logic [RPM_BITS-1:0] RPM_RESET = 8'd10;

	// Command codes carried in tuser
	localparam logic CMD_MOVE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// Full-step coil patterns, indexed by phase mod 4
	localparam logic [3:0] COIL_TABLE [4] = '{4'hA, 4'h6, 4'h5, 4'h9};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PERIOD,
		ST_TRACK
	} top_state_t;

	typedef enum logic [1:0] {
		PU_IDLE,
		PU_MUL,
		PU_DIV,
		PU_DONE
	} pu_state_t;

	typedef struct packed {
		logic start;
		logic [SPR_BITS-1:0] spr;
		logic [RPM_BITS-1:0] rpm;
	} period_req_t;

	typedef struct packed {
		logic done;
		logic [PERIOD_BITS-1:0] period;
	} period_rsp_t;

	typedef struct packed {
		logic start;
		logic reverse;
		logic [STEP_BITS-1:0] steps;
	} track_req_t;

	typedef struct packed {
		logic done;
		logic [POSITION_BITS-1:0] position;
		logic [POSITION_BITS-1:0] max_position;
	} track_rsp_t;

endpackage
`default_nettype wire

>>> hdl/sms_period_unit.sv
`default_nettype none
// Bit-serial step period unit: shift-add multiply, then restoring divide
module sms_period_unit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire sms_pkg::period_req_t req,
	output sms_pkg::period_rsp_t     rsp
);

	sms_pkg::pu_state_t state_q, state_d;

	logic [sms_pkg::PROD_BITS-1:0] mcand_q;
	logic [sms_pkg::RPM_BITS-1:0]  mult_q;
	logic [sms_pkg::PROD_BITS-1:0] acc_q;
	logic [sms_pkg::CNT_BITS-1:0]  cnt_q;
	logic [sms_pkg::DVD_BITS-1:0]  dvd_q;
	logic [sms_pkg::PROD_BITS-1:0] rem_q;
	logic [sms_pkg::DVD_BITS-1:0]  quo_q;

	logic                          last;
	logic [sms_pkg::PROD_BITS:0]   trial;
	logic [sms_pkg::PROD_BITS+1:0] diff;
	logic                          ge;
	logic [sms_pkg::DVD_BITS:0]    inc;

	assign last  = (cnt_q == '0);
	// one quotient bit per cycle
	assign trial = {rem_q, dvd_q[sms_pkg::DVD_BITS-1]};
	assign diff  = {1'b0, trial} - {2'b00, acc_q};
	assign ge    = ~diff[sms_pkg::PROD_BITS+1];

	// period = quotient + 1, saturated to the period range
	assign inc = {1'b0, quo_q} + (sms_pkg::DVD_BITS + 1)'(1);
	assign rsp.done = (state_q == sms_pkg::PU_DONE);
	assign rsp.period = (inc > sms_pkg::PERIOD_CAP) ? sms_pkg::PERIOD_MAX
		: inc[sms_pkg::PERIOD_BITS-1:0];

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sms_pkg::PU_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sms_pkg::PU_IDLE: begin
				if (req.start) state_d = sms_pkg::PU_MUL;
			end
			sms_pkg::PU_MUL: begin
				if (last) state_d = sms_pkg::PU_DIV;
			end
			sms_pkg::PU_DIV: begin
				if (last) state_d = sms_pkg::PU_DONE;
			end
			sms_pkg::PU_DONE: begin
				state_d = sms_pkg::PU_IDLE;
			end
			default: state_d = sms_pkg::PU_IDLE;
		endcase
	end

	// Datapath shift registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (state_q)
				sms_pkg::PU_IDLE: begin
					if (req.start) begin
						mcand_q <= sms_pkg::PROD_BITS'(req.spr);
						mult_q  <= req.rpm;
						acc_q   <= '0;
						cnt_q   <= sms_pkg::CNT_BITS'(sms_pkg::RPM_BITS - 1);
					end
				end
				sms_pkg::PU_MUL: begin
					if (mult_q[0]) acc_q <= acc_q + mcand_q;
					mcand_q <= {mcand_q[sms_pkg::PROD_BITS-2:0], 1'b0};
					mult_q  <= {1'b0, mult_q[sms_pkg::RPM_BITS-1:1]};
					if (last) begin
						cnt_q <= sms_pkg::CNT_BITS'(sms_pkg::DVD_BITS - 1);
						rem_q <= '0;
						dvd_q <= sms_pkg::DIVIDEND;
						quo_q <= '0;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				sms_pkg::PU_DIV: begin
					rem_q <= ge ? diff[sms_pkg::PROD_BITS-1:0] : trial[sms_pkg::PROD_BITS-1:0];
					quo_q <= {quo_q[sms_pkg::DVD_BITS-2:0], ge};
					dvd_q <= {dvd_q[sms_pkg::DVD_BITS-2:0], 1'b0};
					cnt_q <= cnt_q - 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

>>> hdl/sms_pos_tracker.sv
`default_nettype none
// Position and extent tracker, updated at the end of a move: position first, then extent
module sms_pos_tracker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire sms_pkg::track_req_t req,
	output sms_pkg::track_rsp_t     rsp
);

	logic [sms_pkg::POSITION_BITS-1:0] pos_q;
	logic [sms_pkg::POSITION_BITS-1:0] max_q;
	logic                              max_pend_q;
	logic                              add_def_q;
	logic [sms_pkg::STEP_BITS-1:0]     deficit_q;

	logic [sms_pkg::POSITION_BITS:0]   steps_ext;
	logic [sms_pkg::POSITION_BITS:0]   sum;
	logic [sms_pkg::POSITION_BITS:0]   diff;
	logic [sms_pkg::POSITION_BITS:0]   short;
	logic [sms_pkg::POSITION_BITS:0]   max_sum;

	assign steps_ext = (sms_pkg::POSITION_BITS + 1)'(req.steps);
	assign sum   = {1'b0, pos_q} + steps_ext;
	assign diff  = {1'b0, pos_q} - steps_ext;
	assign short = steps_ext - {1'b0, pos_q};
	assign max_sum = {1'b0, max_q} + (sms_pkg::POSITION_BITS + 1)'(deficit_q);

	assign rsp.done = max_pend_q;
	assign rsp.position = pos_q;
	assign rsp.max_position = max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			max_q      <= '0;
			max_pend_q <= 1'b0;
			add_def_q  <= 1'b0;
			deficit_q  <= '0;
		end else begin
			max_pend_q <= req.start;
			// the add stage sets the new position, saturating forward, clamped reverse
			if (req.start) begin
				add_def_q <= 1'b0;
				if (!req.reverse) begin
					pos_q <= sum[sms_pkg::POSITION_BITS] ? sms_pkg::POS_MAX
						: sum[sms_pkg::POSITION_BITS-1:0];
				end else if (!diff[sms_pkg::POSITION_BITS]) begin
					pos_q <= diff[sms_pkg::POSITION_BITS-1:0];
				end else begin
					pos_q     <= '0;
					add_def_q <= 1'b1;
					deficit_q <= short[sms_pkg::STEP_BITS-1:0];
				end
			end
			// the extent stage follows position or grows by the shortfall
			if (max_pend_q) begin
				if (add_def_q) begin
					max_q <= max_sum[sms_pkg::POSITION_BITS] ? sms_pkg::POS_MAX
						: max_sum[sms_pkg::POSITION_BITS-1:0];
				end else if (pos_q >= max_q) begin
					max_q <= pos_q;
				end
			end
		end
	end

endmodule
`default_nettype wire

>>> hdl/stepper_move_sequencer_top.sv
`default_nettype none
// Two-phase full-step stepper sequencer. Items on the input stream are either
// a move (tuser = 0, signed step count in tdata) or a one-microsecond tick
// (tuser = 1); every item yields exactly one result item. A tick's result is
// registered as it is accepted; the tick that ends a move first goes through
// the track state (position update runs as an add stage then an extent
// stage). A move accepted while idle computes its step period with a
// bit-serial unit: shift-add multiply for steps_per_rev * rpm, then restoring
// divide; its result is registered when done. One item is in flight at a
// time; the next is taken as soon as the previous result is taken or in the
// same cycle. A move arriving during a running move is flagged as rejected.
module stepper_move_sequencer_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// config write port
	input  wire logic                              cfg_we,
	input  wire logic [sms_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [sms_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	// input stream
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [sms_pkg::IN_DATA_BITS-1:0]   s_tdata,  // step_count
	input  wire logic                              s_tuser,  // command
	// output stream
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// coil_pattern, moving, move_done, rejected, position, max_position
	output logic [sms_pkg::OUT_DATA_BITS-1:0]       m_tdata
);

	sms_pkg::top_state_t state_q, state_d;

	logic [sms_pkg::SPR_BITS-1:0]    spr_q;
	logic [sms_pkg::RPM_BITS-1:0]    rpm_q;

	logic [sms_pkg::PERIOD_BITS-1:0] period_q;
	logic [sms_pkg::PERIOD_BITS-1:0] countdown_q;
	logic [sms_pkg::STEP_BITS-1:0]   phase_q;
	logic [sms_pkg::STEP_BITS-1:0]   target_q;
	logic [sms_pkg::STEP_BITS-1:0]   mag_q;
	logic                            rev_q;
	logic                            busy_q;
	logic [3:0]                      coil_q;

	logic                            m_valid_q;
	logic                            done_q;
	logic                            rej_q;

	sms_pkg::period_req_t pu_req;
	sms_pkg::period_rsp_t pu_rsp;
	sms_pkg::track_req_t  tk_req;
	sms_pkg::track_rsp_t  tk_rsp;

	logic                            in_acc;
	logic                            move_acc;
	logic                            tick_acc;
	logic                            start_period;
	logic                            finish;
	logic                            out_load;
	logic [sms_pkg::PERIOD_BITS-1:0] cnt_dec;
	logic                            expire;
	logic                            at_target;
	logic [sms_pkg::STEP_BITS-1:0]   step_in;
	logic [sms_pkg::STEP_BITS-1:0]   step_neg;
	logic                            step_is_neg;
	logic                            step_fwd;
	logic [sms_pkg::STEP_BITS-1:0]   step_mag;

	// Handshake decode
	assign in_acc   = s_tvalid && s_tready;
	assign move_acc = in_acc && (s_tuser == sms_pkg::CMD_MOVE);
	assign tick_acc = in_acc && (s_tuser == sms_pkg::CMD_TICK);

	// Step count decode
	assign step_in     = s_tdata[sms_pkg::STEP_BITS-1:0];
	assign step_neg    = '0 - step_in;
	assign step_is_neg = step_in[sms_pkg::STEP_BITS-1];
	assign step_fwd    = !step_is_neg && (step_in != '0);
	assign step_mag    = step_is_neg ? step_neg : step_in;

	// Tick countdown
	assign cnt_dec   = (countdown_q == '0) ? '0 : countdown_q - 1'b1;
	assign expire    = (cnt_dec == '0);
	assign at_target = (phase_q == target_q);

	assign start_period = move_acc && !busy_q;
	assign finish       = tick_acc && busy_q && expire && at_target;

	// Sub-unit requests
	assign pu_req.start = start_period;
	assign pu_req.spr   = (spr_q == '0) ? sms_pkg::SPR_BITS'(1) : spr_q;
	assign pu_req.rpm   = (rpm_q == '0) ? sms_pkg::RPM_BITS'(1) : rpm_q;

	assign tk_req.start   = finish;
	assign tk_req.reverse = rev_q;
	assign tk_req.steps   = mag_q;

	sms_period_unit u_period (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (pu_req),
		.rsp    (pu_rsp)
	);

	sms_pos_tracker u_tracker (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (tk_req),
		.rsp    (tk_rsp)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sms_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			sms_pkg::ST_IDLE: begin
				s_tready = !m_valid_q || m_tready;
				if (start_period) begin
					state_d = sms_pkg::ST_PERIOD;
				end else if (finish) begin
					state_d = sms_pkg::ST_TRACK;
				end else if (in_acc) begin
					out_load = 1'b1;
				end
			end
			sms_pkg::ST_PERIOD: begin
				if (pu_rsp.done) begin
					state_d  = sms_pkg::ST_IDLE;
					out_load = 1'b1;
				end
			end
			sms_pkg::ST_TRACK: begin
				if (tk_rsp.done) begin
					state_d  = sms_pkg::ST_IDLE;
					out_load = 1'b1;
				end
			end
			default: state_d = sms_pkg::ST_IDLE;
		endcase
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spr_q <= sms_pkg::SPR_RESET;
			rpm_q <= sms_pkg::RPM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sms_pkg::CFG_STEPS_PER_REV: spr_q <= cfg_data[sms_pkg::SPR_BITS-1:0];
				sms_pkg::CFG_SPEED_RPM:     rpm_q <= cfg_data[sms_pkg::RPM_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// Move state and step sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= '0;
			countdown_q <= '0;
			phase_q     <= '0;
			target_q    <= '0;
			mag_q       <= '0;
			rev_q       <= 1'b0;
			busy_q      <= 1'b0;
			coil_q      <= '0;
		end else begin
			if (start_period) begin
				rev_q    <= !step_fwd;
				mag_q    <= step_mag;
				phase_q  <= step_fwd ? '0 : step_mag;
				target_q <= step_fwd ? step_mag : '0;
			end
			if (state_q == sms_pkg::ST_PERIOD && pu_rsp.done) begin
				period_q    <= pu_rsp.period;
				countdown_q <= pu_rsp.period;
				busy_q      <= 1'b1;
			end
			if (tick_acc && busy_q) begin
				countdown_q <= expire ? period_q : cnt_dec;
				if (expire) begin
					if (at_target) begin
						coil_q <= '0;
						busy_q <= 1'b0;
					end else begin
						coil_q  <= sms_pkg::COIL_TABLE[phase_q[1:0]];
						phase_q <= rev_q ? phase_q - 1'b1 : phase_q + 1'b1;
					end
				end
			end
		end
	end

	// Output register: flags held with the result item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			done_q    <= 1'b0;
			rej_q     <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
			done_q    <= (state_q == sms_pkg::ST_TRACK);
			rej_q     <= move_acc && busy_q;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {
		(sms_pkg::OUT_DATA_BITS - sms_pkg::OUT_FIELD_BITS)'(0),
		tk_rsp.max_position,
		tk_rsp.position,
		rej_q,
		done_q,
		busy_q,
		coil_q
	};

`ifndef SYNTH
	a_period_nonzero : assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> period_q != '0)
		else $error("step period is zero during a move");

	a_countdown_range : assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> countdown_q <= period_q)
		else $error("tick countdown above step period");

	a_fwd_phase : assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !rev_q) |-> phase_q <= target_q)
		else $error("forward phase passed its target");

	a_rev_phase : assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && rev_q) |-> phase_q >= target_q)
		else $error("reverse phase passed its target");

	a_track_idle : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sms_pkg::ST_TRACK) |-> (!busy_q && coil_q == '0 && !m_valid_q))
		else $error("position update while move or result still active");
`endif

endmodule
`default_nettype wire
